// File: design/vgaf_pkg.sv
// shared types and constants for the vertical gradient fill block
// no dependencies
`default_nettype none

package vgaf_pkg;

  localparam int RowW   = 12;   // row_offset field
  localparam int PixInW = 32;   // pixel_in field
  localparam int PixW   = 24;   // pixel_out field
  localparam int ChanW  = 8;    // one color byte
  localparam int CoefW  = 9;    // start and end registers
  localparam int RegHW  = 13;   // box_height register
  localparam int QuoW   = 9;    // quotient magnitude, |diff| * row / h < 512
  localparam int RemW   = QuoW + RowW;  // product magnitude
  localparam int Lanes  = 3;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 13;
  localparam int InDataW  = 48;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_RED   = 3'd0,
    CFG_START_GREEN = 3'd1,
    CFG_START_BLUE  = 3'd2,
    CFG_END_RED     = 3'd3,
    CFG_END_GREEN   = 3'd4,
    CFG_END_BLUE    = 3'd5,
    CFG_BOX_HEIGHT  = 3'd6
  } cfg_idx_e;

  // lane order: 0 blue, 1 green, 2 red, same as the byte order in the pixel
  typedef struct packed {
    logic            neg;
    logic [RemW-1:0] rem;
    logic [QuoW-1:0] quo;
  } lane_t;

  typedef struct packed {
    lane_t [Lanes-1:0] lane;
    logic [PixW-1:0]   pix;
  } item_t;

endpackage

`default_nettype wire

// File: design/vgaf_mul_stage.sv
// first pipeline stage: row clamp, per-lane end-start difference and product
// depends on vgaf_pkg
`default_nettype none

module vgaf_mul_stage #(
  parameter int HeightW = 13
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         en_i,
  input  logic                                         valid_i,
  input  logic [vgaf_pkg::RowW-1:0]                    row_i,
  input  logic [vgaf_pkg::PixW-1:0]                    pix_i,
  input  logic [vgaf_pkg::Lanes-1:0][vgaf_pkg::CoefW-1:0] start_i,
  input  logic [vgaf_pkg::Lanes-1:0][vgaf_pkg::CoefW-1:0] end_i,
  input  logic [HeightW-1:0]                           h_i,
  output logic                                         valid_o,
  output vgaf_pkg::item_t                              data_o
);
  import vgaf_pkg::*;

  localparam int CmpW = (RowW > HeightW) ? RowW : HeightW;

  logic [RowW-1:0]        row_c;
  logic signed [CoefW:0]  diff [Lanes];
  logic [CoefW:0]         diff_abs [Lanes];
  item_t                  data_d;
  item_t                  data_q;
  logic                   valid_q;

  always_comb begin
    // a row at or beyond the height sits on the last row
    if (CmpW'(row_i) >= CmpW'(h_i)) begin
      row_c = RowW'(h_i - HeightW'(1));
    end else begin
      row_c = row_i;
    end
    data_d.pix = pix_i;
    for (int l = 0; l < Lanes; l++) begin
      diff[l] = $signed({end_i[l][CoefW-1], end_i[l]})
              - $signed({start_i[l][CoefW-1], start_i[l]});
      diff_abs[l] = diff[l][CoefW] ? (CoefW+1)'(-diff[l]) : (CoefW+1)'(diff[l]);
      data_d.lane[l].neg = diff[l][CoefW];
      data_d.lane[l].rem = RemW'(diff_abs[l][CoefW-1:0]) * RemW'(row_c);
      data_d.lane[l].quo = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// File: design/vgaf_div_cell.sv
// one cell of the divider chain: settles one quotient bit in all three lanes
// depends on vgaf_pkg
`default_nettype none

module vgaf_div_cell #(
  parameter int HeightW = 13,
  parameter int Shift   = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  vgaf_pkg::item_t       data_i,
  input  logic [HeightW-1:0]    h_i,
  output logic                  valid_o,
  output vgaf_pkg::item_t       data_o
);
  import vgaf_pkg::*;

  localparam int WideW = RemW + HeightW;

  logic [WideW-1:0] dv;
  logic [WideW-1:0] rem_w [Lanes];
  item_t            data_d;
  item_t            data_q;
  logic             valid_q;

  always_comb begin
    dv     = WideW'(h_i) << Shift;
    data_d = data_i;
    for (int l = 0; l < Lanes; l++) begin
      rem_w[l] = WideW'(data_i.lane[l].rem);
      if (rem_w[l] >= dv) begin
        data_d.lane[l].rem        = RemW'(rem_w[l] - dv);
        data_d.lane[l].quo[Shift] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// File: design/vertical_gradient_additive_fill.sv
// channel    | direction | fields (lowest bit up)
// s_axis     | in        | tdata: row_offset[11:0], pixel_in[43:12], zero pad
// m_axis     | out       | tdata: pixel_out[23:0]
// cfg        | in        | cfg_index_i selects the register, cfg_data_i carries it
//
// one item per cycle while m_axis is not stalled; the path is a multiply stage, nine divider
// cells (one quotient bit each) and the add/saturate output register.
// each stage holds its item while the next one is full and stalled, so
// bubbles close up under back-pressure. reset clears all valid flags and the
// registers to zero start/end deltas and a box height of one.
// depends on vgaf_pkg, vgaf_mul_stage, vgaf_div_cell
`default_nettype none

module vertical_gradient_additive_fill #(
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [vgaf_pkg::InDataW-1:0]    s_axis_tdata,  // row_offset, pixel_in
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [vgaf_pkg::PixW-1:0]       m_axis_tdata,  // pixel_out
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [vgaf_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [vgaf_pkg::CfgDataW-1:0]   cfg_data_i
);
  import vgaf_pkg::*;

  localparam int HClog   = $clog2(MAX_HEIGHT + 1);
  localparam int HeightW = (HClog < RegHW) ? HClog : RegHW;
  localparam int Stages  = QuoW + 1;

  logic [Lanes-1:0][CoefW-1:0] start_q;
  logic [Lanes-1:0][CoefW-1:0] end_q;
  logic [RegHW-1:0]            height_q;
  logic [RegHW-1:0]            h_nz;
  logic [HeightW-1:0]          h_eff;

  logic        valid [Stages];
  item_t       data  [Stages];
  logic        en    [Stages];
  logic        out_en;

  logic                     out_valid_q;
  logic [PixW-1:0]          out_data_q;
  logic [PixW-1:0]          out_data_d;
  logic signed [QuoW+1:0]   qs    [Lanes];
  logic signed [QuoW+1:0]   delta [Lanes];
  logic signed [QuoW+2:0]   sum   [Lanes];

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= '0;
      end_q    <= '0;
      height_q <= RegHW'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_START_RED:   start_q[2] <= cfg_data_i[CoefW-1:0];
        CFG_START_GREEN: start_q[1] <= cfg_data_i[CoefW-1:0];
        CFG_START_BLUE:  start_q[0] <= cfg_data_i[CoefW-1:0];
        CFG_END_RED:     end_q[2]   <= cfg_data_i[CoefW-1:0];
        CFG_END_GREEN:   end_q[1]   <= cfg_data_i[CoefW-1:0];
        CFG_END_BLUE:    end_q[0]   <= cfg_data_i[CoefW-1:0];
        CFG_BOX_HEIGHT:  height_q   <= cfg_data_i[RegHW-1:0];
        default: ;
      endcase
    end
  end

  // zero height acts as one, heights past the limit saturate
  always_comb begin
    h_nz = (height_q == '0) ? RegHW'(1) : height_q;
    if (32'(h_nz) > 32'(MAX_HEIGHT)) begin
      h_eff = HeightW'(MAX_HEIGHT);
    end else begin
      h_eff = HeightW'(h_nz);
    end
  end

  // a stage loads when it is empty or its item moves on
  assign out_en = !out_valid_q || m_axis_tready;

  always_comb begin
    en[Stages-1] = !valid[Stages-1] || out_en;
    for (int k = Stages - 2; k >= 0; k--) begin
      en[k] = !valid[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];

  vgaf_mul_stage #(
    .HeightW (HeightW)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[0]),
    .valid_i (s_axis_tvalid),
    .row_i   (s_axis_tdata[RowW-1:0]),
    .pix_i   (s_axis_tdata[RowW+PixW-1:RowW]),
    .start_i (start_q),
    .end_i   (end_q),
    .h_i     (h_eff),
    .valid_o (valid[0]),
    .data_o  (data[0])
  );

  for (genvar k = 1; k < Stages; k++) begin : g_cell
    vgaf_div_cell #(
      .HeightW (HeightW),
      .Shift   (QuoW - k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en[k]),
      .valid_i (valid[k-1]),
      .data_i  (data[k-1]),
      .h_i     (h_eff),
      .valid_o (valid[k]),
      .data_o  (data[k])
    );
  end

  // apply sign (truncation toward zero), add start, add to byte and clamp
  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      qs[l] = data[Stages-1].lane[l].neg
            ? -$signed({2'b00, data[Stages-1].lane[l].quo})
            :  $signed({2'b00, data[Stages-1].lane[l].quo});
      delta[l] = $signed({{2{start_q[l][CoefW-1]}}, start_q[l]}) + qs[l];
      sum[l] = $signed({4'b0000, data[Stages-1].pix[l*ChanW +: ChanW]})
             + $signed({delta[l][QuoW+1], delta[l]});
      if (sum[l] < 0) begin
        out_data_d[l*ChanW +: ChanW] = '0;
      end else if (sum[l] > $signed((QuoW+3)'(255))) begin
        out_data_d[l*ChanW +: ChanW] = '1;
      end else begin
        out_data_d[l*ChanW +: ChanW] = sum[l][ChanW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= valid[Stages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // checks
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> valid[0])
    else $error("accepted item did not enter the multiply stage");

  a_rem_below_h: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid[Stages-1] |-> (data[Stages-1].lane[0].rem < (RemW)'(h_eff))
      && (data[Stages-1].lane[1].rem < (RemW)'(h_eff))
      && (data[Stages-1].lane[2].rem < (RemW)'(h_eff)))
    else $error("divider remainder not below the height");

  a_out_stall_holds_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready && valid[Stages-1] |-> !en[Stages-1])
    else $error("last cell advanced into a stalled output");

  a_h_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    h_eff != '0)
    else $error("effective height is zero");

endmodule

`default_nettype wire
